// ===== hw/rtl/balance_drive_mode_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Balance drive mode controller assertion macros
// Concurrent assertion shorthands; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BALANCE_DRIVE_MODE_CONTROLLER_ASSERT_SVH
`define BALANCE_DRIVE_MODE_CONTROLLER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define BDMC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define BDMC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDMC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BDMC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/bdmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Balance drive mode controller package
// Mode codes, chassis codes, register map and shared structures.
// ----------------------------------------------------------------------------
`default_nettype none

package bdmc_pkg;

	typedef enum logic [1:0] {
		MODE_STOPPED   = 2'd0,
		MODE_STARTING  = 2'd1,
		MODE_BALANCING = 2'd2
	} mode_t;

	localparam logic [1:0] CHASSIS_STARTING = 2'd0;
	localparam logic [1:0] CHASSIS_NORMAL   = 2'd1;
	localparam logic [1:0] CHASSIS_DROPPED  = 2'd2;

	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_STOP_HOLD    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_HOLD   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RPM_LIMIT    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_WINDOW = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_LIMIT   = 3'd6;

	localparam logic [15:0] RST_STOP_HOLD    = 16'd700;
	localparam logic [15:0] RST_START_HOLD   = 16'd500;
	localparam logic [14:0] RST_RPM_LIMIT    = 15'd200;
	localparam logic [14:0] RST_PITCH_WINDOW = 15'd4096;
	localparam logic [15:0] RST_PROP_GAIN    = 16'd3277;
	localparam logic [15:0] RST_DERIV_GAIN   = 16'd6554;
	localparam logic [14:0] RST_DUTY_LIMIT   = 15'd6554;

	typedef struct packed {
		logic [15:0] stop_hold_ms;
		logic [15:0] start_hold_ms;
		logic [14:0] rpm_limit;
		logic [14:0] pitch_window;
		logic [15:0] prop_gain;
		logic [15:0] deriv_gain;
		logic [14:0] duty_limit;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		logic  stop_motor;
		logic  apply_brake;
		logic  reset_targets;
		logic  pd_enable;
	} mode_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdmc_cfg.sv =====
// ----------------------------------------------------------------------------
// Balance drive mode controller configuration registers
// APB-style register file holding the hold times, limits and gains.
// ----------------------------------------------------------------------------
`default_nettype none

module bdmc_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bdmc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output bdmc_pkg::cfg_t                  cfg
);
	import bdmc_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_hold_ms  <= RST_STOP_HOLD;
			cfg_q.start_hold_ms <= RST_START_HOLD;
			cfg_q.rpm_limit     <= RST_RPM_LIMIT;
			cfg_q.pitch_window  <= RST_PITCH_WINDOW;
			cfg_q.prop_gain     <= RST_PROP_GAIN;
			cfg_q.deriv_gain    <= RST_DERIV_GAIN;
			cfg_q.duty_limit    <= RST_DUTY_LIMIT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_STOP_HOLD:    cfg_q.stop_hold_ms  <= pwdata[15:0];
				REG_START_HOLD:   cfg_q.start_hold_ms <= pwdata[15:0];
				REG_RPM_LIMIT:    cfg_q.rpm_limit     <= pwdata[14:0];
				REG_PITCH_WINDOW: cfg_q.pitch_window  <= pwdata[14:0];
				REG_PROP_GAIN:    cfg_q.prop_gain     <= pwdata[15:0];
				REG_DERIV_GAIN:   cfg_q.deriv_gain    <= pwdata[15:0];
				REG_DUTY_LIMIT:   cfg_q.duty_limit    <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STOP_HOLD:    prdata = 32'(cfg_q.stop_hold_ms);
			REG_START_HOLD:   prdata = 32'(cfg_q.start_hold_ms);
			REG_RPM_LIMIT:    prdata = 32'(cfg_q.rpm_limit);
			REG_PITCH_WINDOW: prdata = 32'(cfg_q.pitch_window);
			REG_PROP_GAIN:    prdata = 32'(cfg_q.prop_gain);
			REG_DERIV_GAIN:   prdata = 32'(cfg_q.deriv_gain);
			REG_DUTY_LIMIT:   prdata = 32'(cfg_q.duty_limit);
			default:          prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bdmc_mode.sv =====
// ----------------------------------------------------------------------------
// Balance drive mode controller mode machine
// Stopped / starting / balancing state with accumulated hold timers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdmc_mode #(
	parameter int BALANCE_HOLD_MS = 3000
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [31:0]          time_stamp,
	input  wire logic [1:0]           chassis_state,
	input  wire logic signed [15:0]   pitch,
	input  wire logic signed [15:0]   motor_rpm,
	input  wire bdmc_pkg::cfg_t       cfg,
	output bdmc_pkg::mode_t           mode_cur,
	output bdmc_pkg::mode_flags_t     flags
);
	import bdmc_pkg::*;

	mode_t       mode_q;
	mode_t       mode_ovr;
	mode_t       mode_d;
	logic [31:0] hold_q;
	logic [31:0] hold_ovr;
	logic [31:0] hold_d;
	logic [31:0] hold_sum;
	logic [31:0] last_time_q;
	logic [31:0] dt;
	logic        force_start;
	logic        force_stop;
	logic        in_window;

	assign mode_cur = mode_q;
	assign dt       = time_stamp - last_time_q;

	assign force_start = (chassis_state == CHASSIS_STARTING) &&
		(motor_rpm < $signed({1'b0, cfg.rpm_limit}));
	assign force_stop  = (chassis_state == CHASSIS_DROPPED);
	assign in_window   = (pitch < $signed({1'b0, cfg.pitch_window})) &&
		(pitch > -$signed({1'b0, cfg.pitch_window}));

	// Chassis overrides are applied before the mode's own rules.
	always_comb begin
		mode_ovr = mode_q;
		hold_ovr = hold_q;
		if (force_start) begin
			mode_ovr = MODE_STARTING;
			hold_ovr = '0;
		end else if (force_stop) begin
			mode_ovr = MODE_STOPPED;
			hold_ovr = '0;
		end
	end

	assign hold_sum = hold_ovr + dt;

	// Next state and next hold.
	always_comb begin
		mode_d = mode_ovr;
		hold_d = hold_ovr;
		case (mode_ovr)
			MODE_STOPPED: begin
				if (chassis_state == CHASSIS_STARTING) begin
					if (hold_sum > 32'(cfg.stop_hold_ms)) begin
						mode_d = MODE_STARTING;
						hold_d = '0;
					end else begin
						hold_d = hold_sum;
					end
				end else begin
					hold_d = '0;
				end
			end
			MODE_STARTING: begin
				if (chassis_state != CHASSIS_NORMAL) begin
					hold_d = '0;
				end else if (hold_sum > 32'(cfg.start_hold_ms)) begin
					mode_d = MODE_BALANCING;
					hold_d = '0;
				end else begin
					hold_d = hold_sum;
				end
			end
			MODE_BALANCING: begin
				if (hold_sum >= 32'(BALANCE_HOLD_MS)) begin
					hold_d = '0;
				end else begin
					hold_d = hold_sum;
				end
			end
			default: ;
		endcase
	end

	// Per-step flags.
	always_comb begin
		flags               = '0;
		flags.mode          = mode_d;
		flags.stop_motor    = force_stop && !force_start && (mode_q != MODE_STOPPED);
		case (mode_ovr)
			MODE_STOPPED:   flags.apply_brake = 1'b1;
			MODE_STARTING:  flags.reset_targets = 1'b1;
			MODE_BALANCING: begin
				flags.reset_targets = 1'b1;
				flags.pd_enable     = in_window;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STOPPED;
			hold_q      <= '0;
			last_time_q <= '0;
		end else if (step) begin
			mode_q      <= mode_d;
			hold_q      <= hold_d;
			last_time_q <= time_stamp;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bdmc_pd.sv =====
// ----------------------------------------------------------------------------
// Balance drive mode controller PD law
// Proportional-derivative duty on pitch error, rounded to Q1.15 and clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module bdmc_pd (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               update,
	input  wire logic signed [15:0] pitch,
	input  wire bdmc_pkg::cfg_t     cfg,
	output logic signed [15:0]      duty
);
	import bdmc_pkg::*;

	logic signed [15:0] prev_err_q;
	logic signed [15:0] err;
	logic signed [16:0] diff;
	logic signed [32:0] p_term;
	logic signed [33:0] d_term;
	logic signed [34:0] sum;
	logic signed [34:0] rnd;
	logic signed [25:0] q;
	logic signed [25:0] lim;

	// The error is only used inside the pitch window, so negation cannot overflow.
	assign err    = -pitch;
	assign diff   = 17'(err) - 17'(prev_err_q);
	assign p_term = 33'(err) * 33'($signed({1'b0, cfg.prop_gain}));
	assign d_term = 34'(diff) * 34'($signed({1'b0, cfg.deriv_gain}));
	assign sum    = 35'(p_term) + 35'(d_term);
	assign rnd    = sum + 35'sd256;
	// Arithmetic shift gives floor, so halves round toward plus infinity.
	assign q      = rnd[34:9];
	assign lim    = $signed(26'(cfg.duty_limit));

	always_comb begin
		if (q > lim) begin
			duty = lim[15:0];
		end else if (q < -lim) begin
			duty = 16'(-lim);
		end else begin
			duty = q[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (update) begin
			prev_err_q <= err;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/balance_drive_mode_controller.sv =====
// Path: an accepted transfer passes the input register, then the result register.
// Throughput: one item per cycle, sustained while the result side is not stalled.
// The mode/hold/time state feeds back from its registers to the next item, which sets that rate.
// Reset (arst_n low) clears both stage valids, the mode machine, hold timer,
// last run time, previous error, and loads the register defaults.
// ----------------------------------------------------------------------------
// Balance drive mode controller
// Per-tick stopped / starting / balancing mode machine with a clamped PD
// duty law, an input register, a result register and an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "balance_drive_mode_controller_assert.svh"

module balance_drive_mode_controller #(
	parameter int BALANCE_HOLD_MS = 3000
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bdmc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	// Item channel
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic [31:0]                 time_stamp,
	input  wire logic                        board_ready,
	input  wire logic [1:0]                  chassis_state,
	input  wire logic signed [15:0]          pitch,
	input  wire logic signed [15:0]          motor_rpm,
	// Result channel
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic                             run_status,
	output logic [1:0]                       mode,
	output logic                             stop_motor,
	output logic                             apply_brake,
	output logic                             reset_targets,
	output logic                             duty_valid,
	output logic signed [15:0]               duty
);
	import bdmc_pkg::*;

	cfg_t               cfg;
	mode_t              mode_cur;
	mode_flags_t        flags;
	logic signed [15:0] pd_duty;

	// Input register stage.
	logic               valid_s1;
	logic [31:0]        time_stamp_s1;
	logic               board_ready_s1;
	logic [1:0]         chassis_state_s1;
	logic signed [15:0] pitch_s1;
	logic signed [15:0] motor_rpm_s1;

	// Result register stage.
	logic               valid_s2;
	logic               run_status_s2;
	logic [1:0]         mode_s2;
	logic               stop_motor_s2;
	logic               apply_brake_s2;
	logic               reset_targets_s2;
	logic               duty_valid_s2;
	logic signed [15:0] duty_s2;

	logic in_accept;
	logic out_free;
	logic s1_move;
	logic step;
	logic pd_fire;

	// The result register is free when it is empty or its transfer completes
	// this cycle; the input stage then moves forward and a new item can enter
	// behind it in the same cycle.
	assign out_free   = !valid_s2 || !result_stall;
	assign s1_move    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign in_accept  = item_valid && !item_stall;

	// A tick with the board not ready reports idle and leaves all state alone.
	assign step    = s1_move && board_ready_s1;
	assign pd_fire = step && flags.pd_enable;

	bdmc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdmc_mode #(
		.BALANCE_HOLD_MS (BALANCE_HOLD_MS)
	) u_mode (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.time_stamp    (time_stamp_s1),
		.chassis_state (chassis_state_s1),
		.pitch         (pitch_s1),
		.motor_rpm     (motor_rpm_s1),
		.cfg           (cfg),
		.mode_cur      (mode_cur),
		.flags         (flags)
	);

	bdmc_pd u_pd (
		.clk    (clk),
		.arst_n (arst_n),
		.update (pd_fire),
		.pitch  (pitch_s1),
		.cfg    (cfg),
		.duty   (pd_duty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !s1_move);
			valid_s2 <= s1_move || (valid_s2 && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			time_stamp_s1    <= time_stamp;
			board_ready_s1   <= board_ready;
			chassis_state_s1 <= chassis_state;
			pitch_s1         <= pitch;
			motor_rpm_s1     <= motor_rpm;
		end
	end

	// Not-ready ticks show the current mode with every flag and the duty at zero.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			run_status_s2    <= board_ready_s1;
			mode_s2          <= board_ready_s1 ? flags.mode : mode_cur;
			stop_motor_s2    <= board_ready_s1 && flags.stop_motor;
			apply_brake_s2   <= board_ready_s1 && flags.apply_brake;
			reset_targets_s2 <= board_ready_s1 && flags.reset_targets;
			duty_valid_s2    <= board_ready_s1 && flags.pd_enable;
			duty_s2          <= (board_ready_s1 && flags.pd_enable) ? pd_duty : 16'sd0;
		end
	end

	assign result_valid  = valid_s2;
	assign run_status    = run_status_s2;
	assign mode          = mode_s2;
	assign stop_motor    = stop_motor_s2;
	assign apply_brake   = apply_brake_s2;
	assign reset_targets = reset_targets_s2;
	assign duty_valid    = duty_valid_s2;
	assign duty          = duty_s2;

	// A duty target only comes out of an executed step in balancing mode.
	`BDMC_ASSERT_IMP(a_duty_mode, clk, arst_n, result_valid && duty_valid, run_status && (mode == MODE_BALANCING), "duty issued outside balancing")
	// The issued duty respects the symmetric clamp.
	`BDMC_ASSERT_IMP(a_duty_clamp, clk, arst_n, result_valid && duty_valid, (duty <= $signed({1'b0, cfg.duty_limit})) && (duty >= -$signed({1'b0, cfg.duty_limit})), "duty outside limit")
	// A forced stop always lands in stopped mode.
	`BDMC_ASSERT_IMP(a_stop_mode, clk, arst_n, result_valid && stop_motor, run_status && (mode == MODE_STOPPED), "stop_motor without stopped mode")
	// An idle report carries no action flags.
	`BDMC_ASSERT_IMP(a_idle_quiet, clk, arst_n, result_valid && !run_status, !stop_motor && !apply_brake && !reset_targets && !duty_valid, "idle result with flags set")
	// An empty result register never holds back the item side.
	`BDMC_ASSERT_IMP(a_no_stall_empty, clk, arst_n, !result_valid, !item_stall, "item stalled with empty result register")
	// A completed result transfer with nothing behind it leaves the output empty.
	`BDMC_ASSERT_NXT(a_drain, clk, arst_n, result_valid && !result_stall && !valid_s1, !result_valid, "result repeated after transfer")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Balance drive mode controller testbench
// Sends control ticks through the valid/stall item channel and compares every
// result transfer against a cycle-free model of the mode machine and the PD
// law. A short directed table comes first, then randomized phases under
// several register settings, with random idling on both channels but in the last.
// ----------------------------------------------------------------------------

module tb_top;
	import bdmc_pkg::*;

	// Chassis code 3 has no name in the package; it never forces anything.
	localparam logic [1:0] CHASSIS_OTHER = 2'd3;
	localparam int unsigned BALANCE_HOLD = 3000;
	// Longest run of cycles with no transfer on either channel before the
	// run is declared hung. The deliberate result hold-off is far shorter.
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int REPORT_CAP = 50;

	// One control tick as it appears on the item channel.
	typedef struct packed {
		logic [31:0]        stamp;
		logic               ready;
		logic [1:0]         chassis;
		logic signed [15:0] pitch;
		logic signed [15:0] rpm;
	} tick_t;

	// One result transfer, field for field.
	typedef struct packed {
		logic               run;
		mode_t              mode;
		logic               stop;
		logic               brake;
		logic               clear;
		logic               dvalid;
		logic signed [15:0] duty;
	} drive_out_t;

	// A directed row: the tick, and where the answer is obvious, the answer.
	typedef struct {
		tick_t      tick;
		bit         typed;
		drive_out_t want;
	} vector_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                item_valid;
	logic                item_stall;
	logic [31:0]         time_stamp;
	logic                board_ready;
	logic [1:0]          chassis_state;
	logic signed [15:0]  pitch;
	logic signed [15:0]  motor_rpm;
	logic                result_valid;
	logic                result_stall;
	logic                run_status;
	logic [1:0]          mode;
	logic                stop_motor;
	logic                apply_brake;
	logic                reset_targets;
	logic                duty_valid;
	logic signed [15:0]  duty;

	balance_drive_mode_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.time_stamp    (time_stamp),
		.board_ready   (board_ready),
		.chassis_state (chassis_state),
		.pitch         (pitch),
		.motor_rpm     (motor_rpm),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.run_status    (run_status),
		.mode          (mode),
		.stop_motor    (stop_motor),
		.apply_brake   (apply_brake),
		.reset_targets (reset_targets),
		.duty_valid    (duty_valid),
		.duty          (duty)
	);

	// Model state: the register copy and the controller state, kept in step
	// with the block by updating them at each accepted transfer or write.
	cfg_t        ctl_cfg;
	mode_t       ctl_mode;
	logic [31:0] hold_ms;
	logic [31:0] last_stamp;
	int          last_error;

	drive_out_t  expected_drive[$];
	vector_t     directed[$];
	int          mismatches;
	int          quiet_cycles;
	bit          idling_on;
	bit          pressure_req;

	// State of the random tick generator. Chassis states come in runs so that
	// the hold timers actually reach their thresholds.
	logic [1:0]  scene_chassis;
	int          scene_left;
	logic [31:0] next_stamp;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Computes the result of one tick and advances the model state. The PD
	// sum is exact in 64 bits; the shift by nine is a floor division by 512,
	// so adding 256 first rounds half-way cases toward plus infinity.
	function automatic drive_out_t step_controller(tick_t t);
		drive_out_t  r;
		logic [31:0] dt;
		int          e;
		int          d;
		longint      s;
		longint      q;
		longint      lim;
		longint      pg;
		longint      dg;
		r = '0;
		r.mode = ctl_mode;
		if (!t.ready)
			return r;
		dt = t.stamp - last_stamp;
		if (t.chassis == CHASSIS_STARTING && int'(t.rpm) < int'(ctl_cfg.rpm_limit)) begin
			ctl_mode = MODE_STARTING;
			hold_ms = 32'd0;
		end else if (t.chassis == CHASSIS_DROPPED) begin
			r.stop = (ctl_mode != MODE_STOPPED);
			ctl_mode = MODE_STOPPED;
			hold_ms = 32'd0;
		end
		case (ctl_mode)
			MODE_STOPPED: begin
				r.brake = 1'b1;
				if (t.chassis == CHASSIS_STARTING) begin
					hold_ms = hold_ms + dt;
					if (hold_ms > ctl_cfg.stop_hold_ms) begin
						ctl_mode = MODE_STARTING;
						hold_ms = 32'd0;
					end
				end else begin
					hold_ms = 32'd0;
				end
			end
			MODE_STARTING: begin
				r.clear = 1'b1;
				if (t.chassis == CHASSIS_NORMAL)
					hold_ms = hold_ms + dt;
				else
					hold_ms = 32'd0;
				if (hold_ms > ctl_cfg.start_hold_ms) begin
					ctl_mode = MODE_BALANCING;
					hold_ms = 32'd0;
				end
			end
			MODE_BALANCING: begin
				r.clear = 1'b1;
				if (int'(t.pitch) < int'(ctl_cfg.pitch_window) &&
						int'(t.pitch) > -int'(ctl_cfg.pitch_window)) begin
					e = -int'(t.pitch);
					d = e - last_error;
					pg = longint'(ctl_cfg.prop_gain);
					dg = longint'(ctl_cfg.deriv_gain);
					s = longint'(e) * pg + longint'(d) * dg;
					q = (s + 256) >>> 9;
					lim = longint'(ctl_cfg.duty_limit);
					if (q > lim)
						q = lim;
					else if (q < -lim)
						q = -lim;
					last_error = e;
					r.dvalid = 1'b1;
					r.duty = q[15:0];
				end
				// The balancing hold only wraps around; it never changes the mode.
				hold_ms = hold_ms + dt;
				if (hold_ms >= BALANCE_HOLD)
					hold_ms = 32'd0;
			end
			default: ;
		endcase
		last_stamp = t.stamp;
		r.run = 1'b1;
		r.mode = ctl_mode;
		return r;
	endfunction

	function automatic void add_row(logic [31:0] ts, logic rdy, logic [1:0] cst, int p, int r);
		vector_t v;
		v.tick = '{ts, rdy, cst, p[15:0], r[15:0]};
		v.typed = 1'b0;
		v.want = '0;
		directed.push_back(v);
	endfunction

	function automatic void add_known(logic [31:0] ts, logic rdy, logic [1:0] cst, int p, int r,
			logic run, mode_t m, logic stop, logic brake, logic clear);
		vector_t v;
		v.tick = '{ts, rdy, cst, p[15:0], r[15:0]};
		v.typed = 1'b1;
		v.want = '{run, m, stop, brake, clear, 1'b0, 16'sd0};
		directed.push_back(v);
	endfunction

	function automatic void check_field(string name, logic signed [15:0] want,
			logic signed [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Register writes have a setup and an access phase, followed by an idle wait
	// so that psel never gets two assignments in the same time step.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_STOP_HOLD:    ctl_cfg.stop_hold_ms = val[15:0];
			REG_START_HOLD:   ctl_cfg.start_hold_ms = val[15:0];
			REG_RPM_LIMIT:    ctl_cfg.rpm_limit = val[14:0];
			REG_PITCH_WINDOW: ctl_cfg.pitch_window = val[14:0];
			REG_PROP_GAIN:    ctl_cfg.prop_gain = val[15:0];
			REG_DERIV_GAIN:   ctl_cfg.deriv_gain = val[15:0];
			REG_DUTY_LIMIT:   ctl_cfg.duty_limit = val[14:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_setting(input cfg_t c);
		write_reg(REG_STOP_HOLD, 32'(c.stop_hold_ms));
		write_reg(REG_START_HOLD, 32'(c.start_hold_ms));
		write_reg(REG_RPM_LIMIT, 32'(c.rpm_limit));
		write_reg(REG_PITCH_WINDOW, 32'(c.pitch_window));
		write_reg(REG_PROP_GAIN, 32'(c.prop_gain));
		write_reg(REG_DERIV_GAIN, 32'(c.deriv_gain));
		write_reg(REG_DUTY_LIMIT, 32'(c.duty_limit));
	endtask

	// Offers one tick and holds it until the block takes it. The expectation
	// is queued at the accepting edge; a random gap may follow.
	task automatic send_tick(input tick_t t, input bit typed, input drive_out_t want);
		drive_out_t predicted;
		item_valid <= 1'b1;
		time_stamp <= t.stamp;
		board_ready <= t.ready;
		chassis_state <= t.chassis;
		pitch <= t.pitch;
		motor_rpm <= t.rpm;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		predicted = step_controller(t);
		expected_drive.push_back(typed ? want : predicted);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Waits until every queued result has come back, so registers can change.
	task automatic drain;
		item_valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed sequences: runs of one chassis state, small time
	// steps, pitch inside the window and rpm near the limit. Not-ready ticks,
	// drop-overs, time jumps and raw random fields are the noise around it.
	task automatic run_random(input int count, input int dt_max);
		tick_t t;
		int    k;
		int    w;
		int    pv;
		int    done;
		done = 0;
		while (done < count) begin
			if (scene_left == 0) begin
				k = $urandom_range(0, 19);
				if (k < 5)
					scene_chassis = CHASSIS_STARTING;
				else if (k < 15)
					scene_chassis = CHASSIS_NORMAL;
				else if (k < 17)
					scene_chassis = CHASSIS_DROPPED;
				else
					scene_chassis = CHASSIS_OTHER;
				scene_left = $urandom_range(1, 40);
			end
			scene_left--;
			if ($urandom_range(0, 99) < 4)
				next_stamp = $urandom;
			else
				next_stamp = next_stamp + $urandom_range(0, dt_max);
			t.stamp = next_stamp;
			t.ready = ($urandom_range(0, 9) != 0);
			t.chassis = scene_chassis;
			w = int'(ctl_cfg.pitch_window);
			k = $urandom_range(0, 9);
			if (w > 0 && k < 7)
				pv = int'($urandom_range(0, 2 * w - 2)) - (w - 1);
			else if (k == 7)
				pv = $urandom_range(0, 1) ? w : -w;
			else
				pv = int'($urandom_range(0, 65535));
			t.pitch = pv[15:0];
			if ($urandom_range(0, 9) < 4)
				t.rpm = 16'($urandom_range(0, 65535));
			else
				t.rpm = 16'(int'(ctl_cfg.rpm_limit) + int'($urandom_range(0, 6)) - 3);
			send_tick(t, 1'b0, '0);
			done++;
		end
	endtask

	// Result side. It stalls in random bursts while idling is on, and once,
	// on request, holds off for a long stretch so the block fills up and has
	// to stall the item channel.
	initial begin : result_side
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (pressure_req) begin
				pressure_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin : result_check
		drive_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: result transfer with nothing expected, expected none, actual mode %0d duty %0d",
						$time, mode, duty);
			end else begin
				want = expected_drive.pop_front();
				check_field("run_status", want.run, run_status);
				check_field("mode", want.mode, mode);
				check_field("stop_motor", want.stop, stop_motor);
				check_field("apply_brake", want.brake, apply_brake);
				check_field("reset_targets", want.clear, reset_targets);
				check_field("duty_valid", want.dvalid, duty_valid);
				check_field("duty", want.duty, duty);
			end
		end
	end

	// Watchdog: a long run of cycles without any transfer means the block hung.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, IDLE_LIMIT, expected_drive.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		cfg_t setting;
		mismatches = 0;
		quiet_cycles = 0;
		idling_on = 1'b1;
		pressure_req = 1'b0;
		scene_left = 0;
		scene_chassis = CHASSIS_NORMAL;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= 32'd0;
		item_valid <= 1'b0;
		time_stamp <= 32'd0;
		board_ready <= 1'b0;
		chassis_state <= CHASSIS_STARTING;
		pitch <= 16'sd0;
		motor_rpm <= 16'sd0;

		// The model starts from the reset register values and stopped mode.
		ctl_cfg = '{stop_hold_ms: RST_STOP_HOLD, start_hold_ms: RST_START_HOLD,
			rpm_limit: RST_RPM_LIMIT, pitch_window: RST_PITCH_WINDOW,
			prop_gain: RST_PROP_GAIN, deriv_gain: RST_DERIV_GAIN,
			duty_limit: RST_DUTY_LIMIT};
		ctl_mode = MODE_STOPPED;
		hold_ms = 32'd0;
		last_stamp = 32'd0;
		last_error = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk with the reset registers: not-ready ticks, several
		// chassis states in each mode, the stop hold crossed with rpm at the
		// limit, the start hold into balancing, the PD law at the window
		// edges and at both clamps, the balancing hold wrap, drop-over from
		// balancing, the low-rpm override and time stamps that wrap.
		add_known(32'd0, 1'b0, CHASSIS_STARTING, 0, 0, 1'b0, MODE_STOPPED, 1'b0, 1'b0, 1'b0);
		add_known(32'd10, 1'b1, CHASSIS_OTHER, 32767, 32767,
			1'b1, MODE_STOPPED, 1'b0, 1'b1, 1'b0);
		add_known(32'd20, 1'b1, CHASSIS_DROPPED, 0, 0, 1'b1, MODE_STOPPED, 1'b0, 1'b1, 1'b0);
		add_known(32'd30, 1'b1, CHASSIS_STARTING, 0, 32767,
			1'b1, MODE_STOPPED, 1'b0, 1'b1, 1'b0);
		add_known(32'd1000, 1'b1, CHASSIS_STARTING, 0, 200,
			1'b1, MODE_STARTING, 1'b0, 1'b1, 1'b0);
		add_row(32'd1100, 1'b1, CHASSIS_NORMAL, 0, 0);
		add_row(32'd1700, 1'b1, CHASSIS_NORMAL, 0, 0);
		add_row(32'd1701, 1'b1, CHASSIS_NORMAL, 0, 0);
		add_row(32'd1702, 1'b1, CHASSIS_NORMAL, -4095, 0);
		add_row(32'd1703, 1'b1, CHASSIS_NORMAL, 4095, 0);
		add_row(32'd1704, 1'b1, CHASSIS_NORMAL, 4096, 0);
		add_row(32'd1705, 1'b1, CHASSIS_NORMAL, -4096, 0);
		add_row(32'd1706, 1'b1, CHASSIS_NORMAL, -32768, -32768);
		add_row(32'd1707, 1'b1, CHASSIS_NORMAL, 16, 0);
		add_row(32'd4800, 1'b1, CHASSIS_NORMAL, 0, 0);
		add_known(32'd4900, 1'b0, CHASSIS_NORMAL, 0, 0, 1'b0, MODE_BALANCING, 1'b0, 1'b0, 1'b0);
		add_row(32'd4901, 1'b1, CHASSIS_OTHER, 1, 0);
		add_known(32'd4902, 1'b1, CHASSIS_DROPPED, 0, 0, 1'b1, MODE_STOPPED, 1'b1, 1'b1, 1'b0);
		add_known(32'd4903, 1'b1, CHASSIS_DROPPED, 0, 0, 1'b1, MODE_STOPPED, 1'b0, 1'b1, 1'b0);
		add_known(32'd4904, 1'b1, CHASSIS_STARTING, 0, -32768,
			1'b1, MODE_STARTING, 1'b0, 1'b0, 1'b1);
		add_row(32'hFFFF_FFF0, 1'b1, CHASSIS_NORMAL, -100, 0);
		add_row(32'h0000_0008, 1'b1, CHASSIS_NORMAL, 0, 0);
		add_known(32'hFFFF_FFFF, 1'b1, CHASSIS_STARTING, 0, 199,
			1'b1, MODE_STARTING, 1'b0, 1'b0, 1'b1);
		add_known(32'h0000_0000, 1'b1, CHASSIS_STARTING, 0, 32767,
			1'b1, MODE_STARTING, 1'b0, 1'b0, 1'b1);
		foreach (directed[i])
			send_tick(directed[i].tick, directed[i].typed, directed[i].want);
		next_stamp = 32'd0;
		drain();

		// Phase one: the reset values, written explicitly.
		write_setting(ctl_cfg);
		run_random(180, 150);
		drain();

		// Phase two: everything at zero, with the long result hold-off.
		setting = '0;
		write_setting(setting);
		pressure_req = 1'b1;
		run_random(180, 20);
		drain();

		// Phase three: everything at its maximum.
		setting = '{stop_hold_ms: 16'hFFFF, start_hold_ms: 16'hFFFF, rpm_limit: 15'h7FFF,
			pitch_window: 15'h7FFF, prop_gain: 16'hFFFF, deriv_gain: 16'hFFFF,
			duty_limit: 15'h7FFF};
		write_setting(setting);
		run_random(180, 6000);
		drain();

		// Phase four: short holds so the modes turn over quickly.
		setting = '{stop_hold_ms: 16'd40, start_hold_ms: 16'd60, rpm_limit: 15'd100,
			pitch_window: 15'd1500, prop_gain: 16'($urandom), deriv_gain: 16'($urandom),
			duty_limit: 15'd9000};
		write_setting(setting);
		run_random(180, 30);
		drain();

		// Phase five: random registers, and no idling on either side.
		setting.stop_hold_ms = 16'($urandom_range(0, 2000));
		setting.start_hold_ms = 16'($urandom_range(0, 2000));
		setting.rpm_limit = 15'($urandom_range(0, 32767));
		setting.pitch_window = 15'($urandom_range(0, 32767));
		setting.prop_gain = 16'($urandom_range(0, 65535));
		setting.deriv_gain = 16'($urandom_range(0, 65535));
		setting.duty_limit = 15'($urandom_range(0, 32767));
		write_setting(setting);
		idling_on = 1'b0;
		run_random(180, 200);
		drain();

		// A final wait catches any result the block sends unasked.
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
